>>> src/pspw_pkg.sv
// ----------------------------------------------------------------------------
// pspw_pkg
// Shared types and constants for the shift-register plane writer.
// ----------------------------------------------------------------------------
package pspw_pkg;

  localparam int LANES  = 8;
  localparam int BYTE_W = 8;
  localparam int IDX_W  = 5;
  localparam int CMD_W  = 2;

  // register file
  localparam int        PADDR_W          = 3;
  localparam int        PDATA_W          = 32;
  localparam logic      REG_HIGH_CYCLES  = 1'b0;   // paddr[2] of the register
  localparam logic [7:0] HIGH_CYCLES_RST = 8'd1;

  typedef enum logic [CMD_W-1:0] {
    OP_TICK       = 2'd0,
    OP_LOAD       = 2'd1,
    OP_LATCH      = 2'd2,
    OP_SOFT_RESET = 2'd3
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [IDX_W-1:0]  byte_index;
    logic [BYTE_W-1:0] byte_value;
    logic              plane_done;
    logic              index_ok;
  } op_t;

endpackage

>>> src/pspw_front.sv
// ----------------------------------------------------------------------------
// pspw_front
// Classifies an incoming word into an operation for the back end.
// ----------------------------------------------------------------------------
module pspw_front #(
  parameter int CHAIN_DEPTH = 32
) (
  input  logic [1:0]      command,
  input  logic [4:0]      byte_index,
  input  logic [7:0]      byte_value,
  input  logic            plane_done,
  output pspw_pkg::op_t   op
);
  import pspw_pkg::*;

  localparam int CHAIN_BYTES = (CHAIN_DEPTH + 7) / 8;
  localparam int PLANE_BYTES = LANES * CHAIN_BYTES;

  op_kind_t kind;

  always_comb begin
    case (command)
      OP_TICK:  kind = OP_TICK;
      OP_LOAD:  kind = OP_LOAD;
      OP_LATCH: kind = OP_LATCH;
      default:  kind = OP_SOFT_RESET;
    endcase
  end

  always_comb begin
    op.kind       = kind;
    op.byte_index = byte_index;
    op.byte_value = byte_value;
    op.plane_done = plane_done;
    // bytes past the plane are dropped, plane_done still counts
    op.index_ok   = ({2'b00, byte_index} < 7'(PLANE_BYTES));
  end

endmodule

>>> src/pspw_fifo.sv
// ----------------------------------------------------------------------------
// pspw_fifo
// Two-entry queue of decoded operations between front and back end.
// ----------------------------------------------------------------------------
module pspw_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pspw_pkg::op_t push_op,
  input  logic          pop,
  output pspw_pkg::op_t pop_op,
  output logic          full,
  output logic          empty
);
  import pspw_pkg::*;

  op_t        entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full   = (count == 2'd2);
  assign empty  = (count == 2'd0);
  assign pop_op = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("queue count out of range");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 2'd1)
    else $error("queue push lost");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue popped while empty");

endmodule

>>> src/pspw_back.sv
// ----------------------------------------------------------------------------
// pspw_back
// Executes queued operations: plane buffers, shift/strobe sequencer, result reg.
// ----------------------------------------------------------------------------
module pspw_back #(
  parameter int CHAIN_DEPTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    high_cycles,
  input  logic          op_valid,
  input  pspw_pkg::op_t op,
  output logic          op_pop,
  input  logic          out_stall,
  output logic          out_valid,
  output logic [7:0]    data_out,
  output logic          shift_clock,
  output logic          store_strobe,
  output logic          ready_for_plane,
  output logic          ready_to_latch
);
  import pspw_pkg::*;

  localparam int CHAIN_BYTES = (CHAIN_DEPTH + 7) / 8;
  localparam int LANE_BITS   = 8 * CHAIN_BYTES;
  localparam int ROW_W       = $clog2(CHAIN_DEPTH);

  localparam logic [3:0] PH_IDLE        = 4'd0;
  localparam logic [3:0] PH_CLK_HI_SET  = 4'd1;
  localparam logic [3:0] PH_CLK_HI_WAIT = 4'd2;
  localparam logic [3:0] PH_CLK_LO_SET  = 4'd3;
  localparam logic [3:0] PH_CLK_LO_WAIT = 4'd4;
  localparam logic [3:0] PH_WRITTEN     = 4'd5;
  localparam logic [3:0] PH_STO_HI_SET  = 4'd6;
  localparam logic [3:0] PH_STO_HI_WAIT = 4'd7;
  localparam logic [3:0] PH_STO_LO_SET  = 4'd8;
  localparam logic [3:0] PH_STO_LO_WAIT = 4'd9;

  // plane storage: one vector per chain, byte k of chain i at bits [8k+7:8k]
  logic [LANE_BITS-1:0]   pending [LANES];
  logic [CHAIN_DEPTH-1:0] active  [LANES];

  logic [3:0]       phase, phase_next;
  logic [7:0]       wait_count, wait_count_next;
  logic [ROW_W-1:0] row, row_next;
  logic             pending_valid, pending_valid_next;
  logic             latch_requested, latch_requested_next;
  logic [7:0]       data_level, data_level_next;
  logic             clock_level, clock_level_next;
  logic             strobe_level, strobe_level_next;

  logic       load_active;
  logic       shift_active;
  logic [7:0] limit;
  logic       set_entry;
  logic [7:0] wc_base;
  logic [7:0] wc_inc;
  logic       elapsed;
  logic [7:0] gather;
  logic       is_tick;

  assign op_pop  = op_valid && (!out_valid || !out_stall);
  assign is_tick = op_pop && (op.kind == OP_TICK);

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      gather[i] = active[i][CHAIN_DEPTH-1];
    end
  end

  // level timer: entering a level restarts the count at this tick
  assign limit     = (high_cycles == 8'd0) ? 8'd1 : high_cycles;
  assign set_entry = (phase == PH_CLK_HI_SET) || (phase == PH_CLK_LO_SET) ||
                     (phase == PH_STO_HI_SET) || (phase == PH_STO_LO_SET);
  assign wc_base   = set_entry ? 8'd0 : wait_count;
  assign wc_inc    = (wc_base == 8'hFF) ? wc_base : wc_base + 8'd1;
  assign elapsed   = (wc_inc >= limit);

  always_comb begin
    phase_next           = phase;
    wait_count_next      = wait_count;
    row_next             = row;
    pending_valid_next   = pending_valid;
    latch_requested_next = latch_requested;
    data_level_next      = data_level;
    clock_level_next     = clock_level;
    strobe_level_next    = strobe_level;
    load_active          = 1'b0;
    shift_active         = 1'b0;
    if (op_pop) begin
      case (op.kind)
        OP_TICK: begin
          case (phase)
            PH_IDLE: begin
              if (pending_valid) begin
                load_active        = 1'b1;
                pending_valid_next = 1'b0;
                row_next           = '0;
                phase_next         = PH_CLK_HI_SET;
              end
            end
            PH_CLK_HI_SET, PH_CLK_HI_WAIT: begin
              if (phase == PH_CLK_HI_SET) begin
                data_level_next  = gather;
                shift_active     = 1'b1;
                clock_level_next = 1'b1;
              end
              if (elapsed) begin
                wait_count_next = 8'd0;
                phase_next      = PH_CLK_LO_SET;
              end else begin
                wait_count_next = wc_inc;
                phase_next      = PH_CLK_HI_WAIT;
              end
            end
            PH_CLK_LO_SET, PH_CLK_LO_WAIT: begin
              if (phase == PH_CLK_LO_SET) begin
                clock_level_next = 1'b0;
              end
              if (elapsed) begin
                wait_count_next = 8'd0;
                row_next        = row + ROW_W'(1);
                if (row == ROW_W'(CHAIN_DEPTH - 1)) begin
                  phase_next = PH_WRITTEN;
                end else begin
                  phase_next = PH_CLK_HI_SET;
                end
              end else begin
                wait_count_next = wc_inc;
                phase_next      = PH_CLK_LO_WAIT;
              end
            end
            PH_WRITTEN: begin
              if (latch_requested) begin
                latch_requested_next = 1'b0;
                phase_next           = PH_STO_HI_SET;
              end
            end
            PH_STO_HI_SET, PH_STO_HI_WAIT: begin
              if (phase == PH_STO_HI_SET) begin
                strobe_level_next = 1'b1;
              end
              if (elapsed) begin
                wait_count_next = 8'd0;
                phase_next      = PH_STO_LO_SET;
              end else begin
                wait_count_next = wc_inc;
                phase_next      = PH_STO_HI_WAIT;
              end
            end
            PH_STO_LO_SET, PH_STO_LO_WAIT: begin
              if (phase == PH_STO_LO_SET) begin
                strobe_level_next = 1'b0;
              end
              if (elapsed) begin
                wait_count_next = 8'd0;
                phase_next      = PH_IDLE;
              end else begin
                wait_count_next = wc_inc;
                phase_next      = PH_STO_LO_WAIT;
              end
            end
            default: begin
              phase_next = PH_IDLE;
            end
          endcase
        end
        OP_LOAD: begin
          if (op.plane_done) begin
            pending_valid_next = 1'b1;
          end
        end
        OP_LATCH: begin
          latch_requested_next = 1'b1;
        end
        default: begin
          phase_next           = PH_IDLE;
          wait_count_next      = 8'd0;
          row_next             = '0;
          pending_valid_next   = 1'b0;
          latch_requested_next = 1'b0;
        end
      endcase
    end
  end

  // pending plane: written at a decoded byte position
  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      for (int k = 0; k < CHAIN_BYTES; k++) begin
        if (op_pop && (op.kind == OP_LOAD) && op.index_ok &&
            ({2'b00, op.byte_index} == 7'(i * CHAIN_BYTES + k))) begin
          pending[i][8*k +: 8] <= op.byte_value;
        end
      end
    end
  end

  // active plane: parallel load, then shift out MSB first
  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      if (load_active) begin
        active[i] <= pending[i][CHAIN_DEPTH-1:0];
      end else if (shift_active) begin
        active[i] <= {active[i][CHAIN_DEPTH-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      wait_count      <= 8'd0;
      row             <= '0;
      pending_valid   <= 1'b0;
      latch_requested <= 1'b0;
      data_level      <= 8'd0;
      clock_level     <= 1'b0;
      strobe_level    <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      phase           <= phase_next;
      wait_count      <= wait_count_next;
      row             <= row_next;
      pending_valid   <= pending_valid_next;
      latch_requested <= latch_requested_next;
      data_level      <= data_level_next;
      clock_level     <= clock_level_next;
      strobe_level    <= strobe_level_next;
      if (op_pop) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop) begin
      data_out        <= data_level_next;
      shift_clock     <= clock_level_next;
      store_strobe    <= strobe_level_next;
      ready_for_plane <= (phase_next == PH_IDLE);
      ready_to_latch  <= (phase_next == PH_WRITTEN);
    end
  end

  a_wait_zero: assert property (@(posedge clk) disable iff (rst)
    !(phase == PH_CLK_HI_WAIT || phase == PH_CLK_LO_WAIT ||
      phase == PH_STO_HI_WAIT || phase == PH_STO_LO_WAIT) |-> wait_count == 8'd0)
    else $error("wait count left running outside a wait phase");

  a_phase_legal: assert property (@(posedge clk) disable iff (rst)
    phase <= PH_STO_LO_WAIT)
    else $error("sequencer in unused phase code");

  a_pop_result: assert property (@(posedge clk) disable iff (rst)
    op_pop |=> out_valid)
    else $error("executed word produced no result");

  a_tick_only_moves: assert property (@(posedge clk) disable iff (rst)
    !is_tick && !(op_pop && op.kind == OP_SOFT_RESET) |=> $stable(phase))
    else $error("phase moved without a tick or soft reset");

endmodule

>>> src/parallel_shift_register_plane_writer.sv
// ----------------------------------------------------------------------------
// parallel_shift_register_plane_writer
// Feeds eight parallel shift-register chains from a byte-loaded bit plane.
// ----------------------------------------------------------------------------
//  channel  signals                                   direction
//  in       in_valid/in_stall, command, byte_index,   into block
//           byte_value, plane_done
//  out      out_valid/out_stall, data_out,            out of block
//           shift_clock, store_strobe,
//           ready_for_plane, ready_to_latch
//  cfg      psel/penable/pwrite/paddr/pwdata/prdata   APB, high_cycles at 0x0
//
//  One word per cycle sustained while out_stall is low; an accepted word is
//  queued, then executed by the back end and lands in the output register.
//  A two-entry queue sits between front and back; in_stall is high while it
//  is full, which only happens when out_stall holds the output register.
//  Reset clears control state and sets high_cycles to 1; plane buffers
//  hold undefined data until loaded.
// ----------------------------------------------------------------------------
module parallel_shift_register_plane_writer #(
  parameter int CHAIN_DEPTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pspw_pkg::PADDR_W-1:0]    paddr,
  input  logic [pspw_pkg::PDATA_W-1:0]    pwdata,
  output logic [pspw_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      command,
  input  logic [4:0]                      byte_index,
  input  logic [7:0]                      byte_value,
  input  logic                            plane_done,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      data_out,
  output logic                            shift_clock,
  output logic                            store_strobe,
  output logic                            ready_for_plane,
  output logic                            ready_to_latch
);
  import pspw_pkg::*;

  logic [7:0] high_cycles;
  logic       cfg_write;
  op_t        front_op;
  op_t        back_op;
  logic       q_full;
  logic       q_empty;
  logic       q_push;
  logic       q_pop;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_HIGH_CYCLES);
  assign prdata    = (paddr[2] == REG_HIGH_CYCLES) ? {24'd0, high_cycles} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_cycles <= HIGH_CYCLES_RST;
    end else if (cfg_write) begin
      high_cycles <= pwdata[7:0];
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  pspw_front #(
    .CHAIN_DEPTH(CHAIN_DEPTH)
  ) u_front (
    .command    (command),
    .byte_index (byte_index),
    .byte_value (byte_value),
    .plane_done (plane_done),
    .op         (front_op)
  );

  pspw_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_op (front_op),
    .pop     (q_pop),
    .pop_op  (back_op),
    .full    (q_full),
    .empty   (q_empty)
  );

  pspw_back #(
    .CHAIN_DEPTH(CHAIN_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .high_cycles     (high_cycles),
    .op_valid        (!q_empty),
    .op              (back_op),
    .op_pop          (q_pop),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .data_out        (data_out),
    .shift_clock     (shift_clock),
    .store_strobe    (store_strobe),
    .ready_for_plane (ready_for_plane),
    .ready_to_latch  (ready_to_latch)
  );

endmodule
